// ===== design/npf_pkg.sv =====
// Shared constants, codes and entry types for the nested block profiler.
package npf_pkg;

  localparam int REGION_COUNT = 128;
  localparam int NEST_DEPTH   = 16;

  localparam int REGION_W = $clog2(REGION_COUNT);
  localparam int LEVEL_W  = $clog2(NEST_DEPTH + 1);
  localparam int FRAME_W  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  localparam int OP_W     = 2;
  localparam int RIDX_W   = 7;
  localparam int TICK_W   = 64;
  localparam int STATUS_W = 2;
  localparam int HITS_W   = 32;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 168;

  localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
  localparam logic [OP_W-1:0] OP_EXIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [HITS_W-1:0] hits;
    logic [TICK_W-1:0] excl;
    logic [TICK_W-1:0] incl;
  } region_entry_t;

  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic [REGION_W-1:0] parent;
    logic [TICK_W-1:0]   start;
    logic [TICK_W-1:0]   saved;
  } frame_t;

endpackage

// ===== design/npf_region_mem.sv =====
// Region counter table: two registered read ports, one write port, valid bits for reset.
module npf_region_mem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [npf_pkg::REGION_W-1:0]    rd_addr_a_i,
  input  logic [npf_pkg::REGION_W-1:0]    rd_addr_b_i,
  output npf_pkg::region_entry_t          rd_data_a_o,
  output npf_pkg::region_entry_t          rd_data_b_o,
  input  logic                            wr_en_i,
  input  logic [npf_pkg::REGION_W-1:0]    wr_addr_i,
  input  npf_pkg::region_entry_t          wr_data_i
);

  npf_pkg::region_entry_t mem [npf_pkg::REGION_COUNT];
  logic [npf_pkg::REGION_COUNT-1:0] valid_q;
  npf_pkg::region_entry_t rd_a_q, rd_b_q;
  logic vld_a_q, vld_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_a_q <= valid_q[rd_addr_a_i];
        vld_b_q <= valid_q[rd_addr_b_i];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data_a_o = vld_a_q ? rd_a_q : '0;
  assign rd_data_b_o = vld_b_q ? rd_b_q : '0;

endmodule

// ===== design/npf_frame_mem.sv =====
// Nesting stack frame store: one registered read port, one write port.
module npf_frame_mem (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [npf_pkg::FRAME_W-1:0]   rd_addr_i,
  output npf_pkg::frame_t               rd_data_o,
  input  logic                          wr_en_i,
  input  logic [npf_pkg::FRAME_W-1:0]   wr_addr_i,
  input  npf_pkg::frame_t               wr_data_i
);

  npf_pkg::frame_t mem [npf_pkg::NEST_DEPTH];
  npf_pkg::frame_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== design/nested_block_profiler.sv =====
// Nested block profiler top level: control sequencer, stack pointer and result register.
//
// Times nested code regions against a 64-bit tick counter. Each input word is an
// enter, an exit or a read-and-clear; each produces exactly one result word. Enter,
// read-and-clear, op 3 and the overflow/underflow cases go straight to the state that
// writes the result; an exit first reads the stack frame, then reads the region and
// parent entries through the two read ports of the counter table, and then writes
// both entries back through its single write port. Items are handled one at a time; a
// new word is accepted while the previous result still waits in the output register.
// The counter table comes out of reset as all zero at once (per-entry valid bits),
// with no clearing pass.
module nested_block_profiler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [6:0] region_index, [70:7] timestamp, [71] zero
  input  logic [npf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] op
  input  logic [npf_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] status, [65:2] inclusive_ticks, [129:66] exclusive_ticks,
  // [161:130] hit_count, [167:162] zero
  output logic [npf_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_ENTER, S_FRAME, S_DATA, S_WR_R, S_READ, S_TRIV
  } state_e;

  state_e state_q, state_d;
  logic [npf_pkg::LEVEL_W-1:0]  level_q, level_d;
  logic [npf_pkg::REGION_W-1:0] parent_q, parent_d;
  logic [npf_pkg::REGION_W-1:0] region_q, region_d;
  logic [npf_pkg::TICK_W-1:0]   ts_q, ts_d;
  logic [npf_pkg::TICK_W-1:0]   elapsed_q, elapsed_d;
  logic [npf_pkg::STATUS_W-1:0] status_q, status_d;

  logic                          out_valid_q, out_valid_d;
  logic [npf_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic [npf_pkg::TICK_W-1:0]    out_incl_q, out_incl_d;
  logic [npf_pkg::TICK_W-1:0]    out_excl_q, out_excl_d;
  logic [npf_pkg::HITS_W-1:0]    out_hits_q, out_hits_d;

  logic                          tbl_rd_en, tbl_wr_en;
  logic [npf_pkg::REGION_W-1:0]  tbl_rd_addr_a, tbl_rd_addr_b, tbl_wr_addr;
  npf_pkg::region_entry_t        tbl_rd_a, tbl_rd_b, tbl_wr_data;

  logic                          frm_rd_en, frm_wr_en;
  logic [npf_pkg::FRAME_W-1:0]   frm_rd_addr, frm_wr_addr;
  npf_pkg::frame_t               frm_rd, frm_wr_data;

  logic                          accept, out_free;
  logic [npf_pkg::REGION_W-1:0]  in_region;
  logic [npf_pkg::TICK_W-1:0]    in_ts;
  logic [npf_pkg::LEVEL_W-1:0]   level_m1;

  npf_region_mem u_region_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (tbl_rd_en),
    .rd_addr_a_i (tbl_rd_addr_a),
    .rd_addr_b_i (tbl_rd_addr_b),
    .rd_data_a_o (tbl_rd_a),
    .rd_data_b_o (tbl_rd_b),
    .wr_en_i     (tbl_wr_en),
    .wr_addr_i   (tbl_wr_addr),
    .wr_data_i   (tbl_wr_data)
  );

  npf_frame_mem u_frame_mem (
    .clk_i     (clk_i),
    .rd_en_i   (frm_rd_en),
    .rd_addr_i (frm_rd_addr),
    .rd_data_o (frm_rd),
    .wr_en_i   (frm_wr_en),
    .wr_addr_i (frm_wr_addr),
    .wr_data_i (frm_wr_data)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_region     = s_axis_tdata[npf_pkg::REGION_W-1:0];
  assign in_ts         = s_axis_tdata[npf_pkg::RIDX_W +: npf_pkg::TICK_W];
  assign level_m1      = level_q - 1'b1;

  always_comb begin
    state_d      = state_q;
    level_d      = level_q;
    parent_d     = parent_q;
    region_d     = region_q;
    ts_d         = ts_q;
    elapsed_d    = elapsed_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_incl_d   = out_incl_q;
    out_excl_d   = out_excl_q;
    out_hits_d   = out_hits_q;

    tbl_rd_en     = 1'b0;
    tbl_rd_addr_a = in_region;
    tbl_rd_addr_b = in_region;
    tbl_wr_en     = 1'b0;
    tbl_wr_addr   = region_q;
    tbl_wr_data   = '0;
    frm_rd_en     = 1'b0;
    frm_rd_addr   = level_m1[npf_pkg::FRAME_W-1:0];
    frm_wr_en     = 1'b0;
    frm_wr_addr   = level_q[npf_pkg::FRAME_W-1:0];
    frm_wr_data   = '{region: region_q, parent: parent_q, start: ts_q, saved: tbl_rd_a.incl};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          region_d = in_region;
          ts_d     = in_ts;
          status_d = npf_pkg::ST_OK;
          case (s_axis_tuser)
            npf_pkg::OP_ENTER: begin
              if (level_q == npf_pkg::LEVEL_W'(npf_pkg::NEST_DEPTH)) begin
                status_d = npf_pkg::ST_OVERFLOW;
                state_d  = S_TRIV;
              end else begin
                tbl_rd_en = 1'b1;
                state_d   = S_ENTER;
              end
            end
            npf_pkg::OP_EXIT: begin
              if (level_q == '0) begin
                status_d = npf_pkg::ST_UNDERFLOW;
                state_d  = S_TRIV;
              end else begin
                frm_rd_en = 1'b1;
                state_d   = S_FRAME;
              end
            end
            npf_pkg::OP_READ: begin
              tbl_rd_en = 1'b1;
              state_d   = S_READ;
            end
            default: begin
              state_d = S_TRIV;
            end
          endcase
        end
      end
      S_ENTER: begin
        if (out_free) begin
          frm_wr_en    = 1'b1;
          parent_d     = region_q;
          level_d      = level_q + 1'b1;
          out_valid_d  = 1'b1;
          out_status_d = npf_pkg::ST_OK;
          out_incl_d   = '0;
          out_excl_d   = '0;
          out_hits_d   = '0;
          state_d      = S_IDLE;
        end
      end
      S_FRAME: begin
        tbl_rd_en     = 1'b1;
        tbl_rd_addr_a = frm_rd.region;
        tbl_rd_addr_b = frm_rd.parent;
        elapsed_d     = ts_q - frm_rd.start;
        state_d       = S_DATA;
      end
      S_DATA: begin
        // parent first; when region equals parent the region write below supersedes it
        tbl_wr_en   = 1'b1;
        tbl_wr_addr = frm_rd.parent;
        tbl_wr_data = '{hits: tbl_rd_b.hits, excl: tbl_rd_b.excl - elapsed_q,
                        incl: tbl_rd_b.incl};
        state_d     = S_WR_R;
      end
      S_WR_R: begin
        if (out_free) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_addr = frm_rd.region;
          tbl_wr_data.incl = frm_rd.saved + elapsed_q;
          tbl_wr_data.excl = (frm_rd.region == frm_rd.parent) ? tbl_rd_a.excl
                                                              : tbl_rd_a.excl + elapsed_q;
          tbl_wr_data.hits = (tbl_rd_a.hits == '1) ? tbl_rd_a.hits : tbl_rd_a.hits + 1'b1;
          level_d      = level_m1;
          parent_d     = frm_rd.parent;
          out_valid_d  = 1'b1;
          out_status_d = npf_pkg::ST_OK;
          out_incl_d   = '0;
          out_excl_d   = '0;
          out_hits_d   = '0;
          state_d      = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          tbl_wr_en    = 1'b1;
          tbl_wr_addr  = region_q;
          tbl_wr_data  = '0;
          out_valid_d  = 1'b1;
          out_status_d = npf_pkg::ST_OK;
          out_incl_d   = tbl_rd_a.incl;
          out_excl_d   = tbl_rd_a.excl;
          out_hits_d   = tbl_rd_a.hits;
          state_d      = S_IDLE;
        end
      end
      S_TRIV: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_incl_d   = '0;
          out_excl_d   = '0;
          out_hits_d   = '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      parent_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      parent_q    <= parent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    region_q     <= region_d;
    ts_q         <= ts_d;
    elapsed_q    <= elapsed_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_incl_q   <= out_incl_d;
    out_excl_q   <= out_excl_d;
    out_hits_q   <= out_hits_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_hits_q, out_excl_q, out_incl_q, out_status_q};

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= npf_pkg::LEVEL_W'(npf_pkg::NEST_DEPTH))
    else $error("stack level beyond nest depth");

  a_empty_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q == '0) |-> (parent_q == '0))
    else $error("empty stack with non-root parent");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tbl_rd_en && tbl_wr_en))
    else $error("table read and write in the same cycle");

  a_exit_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR_R && out_free) |=> (level_q == $past(level_m1)))
    else $error("exit did not pop the stack");
`endif

endmodule

// ===== tb/tb_nested_block_profiler.sv =====
// Self-checking testbench for the nested block profiler: directed table, random nesting, stalls.
module tb_nested_block_profiler;
  timeunit 1ns;
  timeprecision 1ps;
  import npf_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_WORDS = 1800;
  localparam int PRESSURE_AT  = 400;
  localparam int PRESSURE_LEN = 150;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TICK_W-1:0]   incl;
    logic [TICK_W-1:0]   excl;
    logic [HITS_W-1:0]   hits;
  } prof_result_t;

  localparam prof_result_t RES_CLEAR     = '{ST_OK, 64'd0, 64'd0, 32'd0};
  localparam prof_result_t RES_OVERFLOW  = '{ST_OVERFLOW, 64'd0, 64'd0, 32'd0};
  localparam prof_result_t RES_UNDERFLOW = '{ST_UNDERFLOW, 64'd0, 64'd0, 32'd0};

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [RIDX_W-1:0] region;
    logic [TICK_W-1:0] ts;
    logic [4:0]        reps;
    logic              typed;
    prof_result_t      want;
  } stim_row_t;

  localparam int ROWS = 22;
  localparam stim_row_t directed_rows [ROWS] = '{
    '{OP_EXIT,  7'd0,   64'd0,                  5'd1,  1'b1, RES_UNDERFLOW},
    '{OP_READ,  7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 5'd1,  1'b1, RES_CLEAR},
    '{OP_SPARE, 7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 5'd1,  1'b1, RES_CLEAR},
    '{OP_ENTER, 7'd1,   64'd100,                5'd1,  1'b0, RES_CLEAR},
    '{OP_ENTER, 7'd127, 64'd150,                5'd1,  1'b0, RES_CLEAR},
    '{OP_READ,  7'd127, 64'd0,                  5'd1,  1'b1, RES_CLEAR},
    '{OP_EXIT,  7'd0,   64'd180,                5'd1,  1'b0, RES_CLEAR},
    '{OP_EXIT,  7'd127, 64'd400,                5'd1,  1'b0, RES_CLEAR},
    '{OP_READ,  7'd1,   64'd0,                  5'd1,  1'b0, RES_CLEAR},
    '{OP_READ,  7'd127, 64'd0,                  5'd1,  1'b0, RES_CLEAR},
    '{OP_READ,  7'd0,   64'd0,                  5'd1,  1'b0, RES_CLEAR},
    // read-and-clear while nested, then the pending exit
    '{OP_ENTER, 7'd1,   64'd1000,               5'd1,  1'b0, RES_CLEAR},
    '{OP_READ,  7'd1,   64'd0,                  5'd1,  1'b0, RES_CLEAR},
    '{OP_EXIT,  7'd0,   64'd1050,               5'd1,  1'b0, RES_CLEAR},
    '{OP_READ,  7'd1,   64'd0,                  5'd1,  1'b0, RES_CLEAR},
    // fill the stack, overflow, unwind across the tick wrap, underflow
    '{OP_ENTER, 7'd85,  64'hFFFF_FFFF_FFFF_FFF0, 5'd16, 1'b0, RES_CLEAR},
    '{OP_ENTER, 7'd42,  64'd0,                  5'd1,  1'b1, RES_OVERFLOW},
    '{OP_EXIT,  7'd0,   64'h10,                 5'd16, 1'b0, RES_CLEAR},
    '{OP_EXIT,  7'd0,   64'h20,                 5'd1,  1'b1, RES_UNDERFLOW},
    '{OP_READ,  7'd85,  64'd0,                  5'd1,  1'b0, RES_CLEAR},
    '{OP_READ,  7'd0,   64'd0,                  5'd1,  1'b0, RES_CLEAR},
    '{OP_READ,  7'd42,  64'd0,                  5'd1,  1'b1, RES_CLEAR}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  nested_block_profiler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // profiler shadow state
  region_entry_t       prof_tab [REGION_COUNT];
  frame_t              nest_stack [NEST_DEPTH];
  int                  nest_level;
  logic [REGION_W-1:0] cur_parent;

  prof_result_t pending_results [$];
  int           mismatch_cnt;
  int           quiet_cycles;
  int           rx_words;
  bit           tx_burst;

  function automatic prof_result_t profile_event(logic [OP_W-1:0] op,
                                                 logic [REGION_W-1:0] region,
                                                 logic [TICK_W-1:0] ts);
    prof_result_t res;
    frame_t       fr;
    logic [TICK_W-1:0] elapsed;
    res = RES_CLEAR;
    case (op)
      OP_ENTER: begin
        if (nest_level >= NEST_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          fr.region = region;
          fr.parent = cur_parent;
          fr.start  = ts;
          fr.saved  = prof_tab[region].incl;
          nest_stack[nest_level] = fr;
          cur_parent = region;
          nest_level++;
        end
      end
      OP_EXIT: begin
        if (nest_level == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          nest_level--;
          fr = nest_stack[nest_level];
          elapsed = ts - fr.start;
          cur_parent = fr.parent;
          prof_tab[fr.parent].excl = prof_tab[fr.parent].excl - elapsed;
          prof_tab[fr.region].excl = prof_tab[fr.region].excl + elapsed;
          prof_tab[fr.region].incl = fr.saved + elapsed;
          if (prof_tab[fr.region].hits != '1)
            prof_tab[fr.region].hits = prof_tab[fr.region].hits + 1'b1;
        end
      end
      OP_READ: begin
        res.incl = prof_tab[region].incl;
        res.excl = prof_tab[region].excl;
        res.hits = prof_tab[region].hits;
        prof_tab[region] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [RIDX_W-1:0] pick_region();
    if ($urandom_range(0, 9) < 7)
      return RIDX_W'($urandom_range(0, 7));
    return RIDX_W'($urandom_range(0, REGION_COUNT - 1));
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [RIDX_W-1:0] region,
                           input logic [TICK_W-1:0] ts, input logic typed,
                           input prof_result_t want);
    prof_result_t pred;
    int unsigned  gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, ts, region};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = profile_event(op, region, ts);
    pending_results.push_back(typed ? want : pred);
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input logic [TICK_W-1:0] want,
                             input logic [TICK_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result checker
  always @(posedge clk_i) begin
    prof_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, got %0h", $time, m_axis_tdata);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", TICK_W'(want.status), TICK_W'(m_axis_tdata[1:0]));
        check_field("inclusive_ticks", want.incl, m_axis_tdata[65:2]);
        check_field("exclusive_ticks", want.excl, m_axis_tdata[129:66]);
        check_field("hit_count", TICK_W'(want.hits), TICK_W'(m_axis_tdata[161:130]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result receiver, with one long hold-off to back the block up
  initial begin
    int unsigned hold;
    bit          rx_burst;
    m_axis_tready <= 1'b0;
    rx_words = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      rx_burst = ((rx_words / 100) % 3) == 2;
      if (rx_words == PRESSURE_AT)
        hold = PRESSURE_LEN;
      else
        hold = rx_burst ? 0 : $urandom_range(0, 12);
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      rx_words++;
    end
  end

  initial begin
    int               r;
    int               k;
    int               i;
    int unsigned      pick;
    bit               deep;
    logic [OP_W-1:0]  op;
    logic [RIDX_W-1:0] region;
    logic [TICK_W-1:0] ts;
    logic [TICK_W-1:0] tick_now;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_ENTER;
    foreach (prof_tab[j]) prof_tab[j] = '0;
    nest_level   = 0;
    cur_parent   = '0;
    mismatch_cnt = 0;
    quiet_cycles = 0;
    tx_burst     = 1'b0;
    tick_now     = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < ROWS; r++)
      for (k = 0; k < directed_rows[r].reps; k++)
        send_word(directed_rows[r].op, directed_rows[r].region, directed_rows[r].ts,
                  directed_rows[r].typed, directed_rows[r].want);

    for (i = 0; i < RANDOM_WORDS; i++) begin
      tx_burst = ((i / 90) % 3) == 1;
      deep = ((i / 60) % 2) == 0;
      if ($urandom_range(0, 24) == 0)
        tick_now = {$urandom, $urandom};
      else
        tick_now = tick_now + $urandom_range(0, 2000);
      pick = $urandom_range(0, 99);
      if (pick < (deep ? 55 : 30))
        op = OP_ENTER;
      else if (pick < (deep ? 85 : 75))
        op = OP_EXIT;
      else if (pick < 98)
        op = OP_READ;
      else
        op = OP_SPARE;
      region = pick_region();
      ts = (op == OP_READ || op == OP_SPARE) ? {$urandom, $urandom} : tick_now;
      send_word(op, region, ts, 1'b0, RES_CLEAR);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
